// File: sv/bhcs_pkg.sv
// ----------------------------------------------------------------------------
// bhcs_pkg
// shared types, tables, register codes and helpers for the hall commutation
// and speed loop unit
// ----------------------------------------------------------------------------
package bhcs_pkg;

    // defaults for the top level parameters
    localparam int unsigned PWM_PERIOD_US_DEF   = 2000;
    localparam int unsigned REPORT_INTERVAL_DEF = 10;

    // register map, word index = paddr[3:2]
    localparam logic [1:0] REG_TARGET = 2'd0;
    localparam logic [1:0] REG_ORIGIN = 2'd1;
    localparam logic [1:0] REG_GAIN   = 2'd2;

    localparam int unsigned ADDR_W     = 4;
    localparam logic [9:0]  GAIN_RESET = 10'd300;
    localparam logic [6:0]  DUTY_FULL  = 7'd100;
    localparam logic [10:0] PW_SAT     = 11'h7FF;

    // x*5/3 ~= (x*3415) >> 11, exact after truncation for |x| <= 128
    localparam logic [19:0] VEL_RECIP = 20'd3415;
    localparam int unsigned VEL_SHIFT = 11;

    // switch pattern per drive state, bit0 ph1 low .. bit5 ph3 high
    localparam logic [5:0] SW_TABLE [8] = '{
        6'h12, 6'h18, 6'h09, 6'h21, 6'h24, 6'h06, 6'h00, 6'h00
    };

    // rotor state per hall pattern, 7 marks the invalid patterns
    localparam logic [2:0] HALL_MAP [8] = '{
        3'd7, 3'd5, 3'd3, 3'd4, 3'd1, 3'd0, 3'd2, 3'd7
    };

    // commutation result
    typedef struct packed {
        logic [5:0] sw;
        logic [7:0] pos;
    } com_t;

    // speed loop result
    typedef struct packed {
        logic              fwd;
        logic [10:0]       pw;
        logic signed [8:0] vel;
        logic              report;
    } spd_t;

    // on-time for a duty, evaluated only at elaboration
    function automatic logic [10:0] pw_calc(input int unsigned period,
                                            input int unsigned duty);
        logic [63:0] p;
        p = 64'(period) * 64'(duty) / 64'd100;
        return (p > 64'(PW_SAT)) ? PW_SAT : p[10:0];
    endfunction

    // velocity from an 8-bit signed position delta, truncated toward zero
    function automatic logic signed [8:0] vel_of(input logic [7:0] delta);
        logic [7:0]  mag;
        logic [19:0] prod;
        logic [8:0]  q;
        mag  = delta[7] ? 8'(-delta) : delta;
        prod = 20'(mag) * VEL_RECIP;
        q    = 9'(prod >> VEL_SHIFT);
        return signed'(delta[7] ? 9'(-q) : q);
    endfunction

endpackage

// File: sv/bhcs_commutate.sv
// ----------------------------------------------------------------------------
// bhcs_commutate
// hall decode, drive state with lead and origin, switch pattern and
// rotor position tracking
// ----------------------------------------------------------------------------
module bhcs_commutate
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [2:0]       hall_bits,
    input  logic [2:0]       origin,
    input  logic             fwd,
    output logic [7:0]       pos_cur,
    output bhcs_pkg::com_t   com
);

    logic [7:0] pos_reg;
    logic [7:0] pos_next;
    logic [2:0] last_rs_reg;
    logic [2:0] rs;
    logic [4:0] lead;
    logic [4:0] sum;
    logic [2:0] ds;
    logic [3:0] diff;
    logic [7:0] step;

    always_comb
    begin
        rs   = bhcs_pkg::HALL_MAP[hall_bits];
        lead = fwd ? 5'd2 : 5'd30;
        sum  = {2'b00, rs} - {2'b00, origin} + lead + 5'd6;

        // sum spans -3..15; a negative sum keeps its two's complement low bits
        priority if (sum[4])
            ds = sum[2:0];
        else if (sum >= 5'd12)
            ds = 3'(sum - 5'd12);
        else if (sum >= 5'd6)
            ds = 3'(sum - 5'd6);
        else
            ds = sum[2:0];

        // a jump of five is one step the other way round
        diff = {1'b0, rs} - {1'b0, last_rs_reg};
        priority if (diff == 4'd5)
            step = 8'hFF;
        else if (diff == 4'b1011)
            step = 8'd1;
        else
            step = {{4{diff[3]}}, diff};

        pos_next = pos_reg + step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            last_rs_reg <= '0;
        end
        else if (fire)
        begin
            pos_reg     <= pos_next;
            last_rs_reg <= rs;
        end
    end

    assign pos_cur = pos_reg;
    assign com.sw  = bhcs_pkg::SW_TABLE[ds];
    assign com.pos = pos_next;

endmodule

// File: sv/bhcs_speed_loop.sv
// ----------------------------------------------------------------------------
// bhcs_speed_loop
// velocity measurement, proportional duty with lead direction, pwm on-time
// and report tick counter
// ----------------------------------------------------------------------------
module bhcs_speed_loop
#(
    parameter int unsigned PWM_PERIOD_US   = bhcs_pkg::PWM_PERIOD_US_DEF,
    parameter int unsigned REPORT_INTERVAL = bhcs_pkg::REPORT_INTERVAL_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  logic               is_tick,
    input  logic signed [15:0] target,
    input  logic [9:0]         gain,
    input  logic [7:0]         pos_cur,
    input  logic [7:0]         pos_next,
    output logic               fwd_now,
    output bhcs_pkg::spd_t     spd
);

    localparam logic [3:0] RPT = 4'(REPORT_INTERVAL);

    logic [7:0]        plt_reg;
    logic [7:0]        plt_next;
    logic signed [8:0] vel_pre_reg;
    logic signed [8:0] vel_pre_next;
    logic [6:0]        duty_reg;
    logic [6:0]        duty_next;
    logic              fwd_reg;
    logic              fwd_next;
    logic [3:0]        tick_reg;
    logic [3:0]        tick_next;
    logic [3:0]        tick_inc;
    logic              rpt_hit;
    logic signed [16:0] verr;
    logic signed [27:0] err;
    logic [27:0]       err_mag;
    logic [6:0]        duty_err;
    logic [10:0]       pw_lut [128];

    // on-time per duty, constant table
    for (genvar d = 0; d < 128; d++)
    begin : g_pw
        assign pw_lut[d] = bhcs_pkg::pw_calc(PWM_PERIOD_US, d);
    end

    always_comb
    begin
        // velocity for this tick was prepared when the last item left
        verr     = 17'(target) - 17'(vel_pre_reg);
        err      = 28'(verr) * 28'(signed'({1'b0, gain}));
        err_mag  = err[27] ? 28'(-err) : 28'(err);
        duty_err = (err_mag > 28'(bhcs_pkg::DUTY_FULL)) ? bhcs_pkg::DUTY_FULL
                                                         : err_mag[6:0];

        tick_inc = tick_reg + 4'd1;
        rpt_hit  = (tick_inc >= RPT);

        duty_next = duty_reg;
        fwd_next  = fwd_reg;
        tick_next = tick_reg;
        plt_next  = plt_reg;
        if (is_tick)
        begin
            tick_next = rpt_hit ? 4'd0 : tick_inc;
            plt_next  = pos_cur;
            if (target == '0)
                duty_next = bhcs_pkg::DUTY_FULL;
            else
            begin
                duty_next = duty_err;
                fwd_next  = !err[27];
            end
        end

        vel_pre_next = bhcs_pkg::vel_of(pos_next - plt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plt_reg     <= '0;
            vel_pre_reg <= '0;
            duty_reg    <= '0;
            fwd_reg     <= 1'b1;
            tick_reg    <= '0;
        end
        else if (fire)
        begin
            plt_reg     <= plt_next;
            vel_pre_reg <= vel_pre_next;
            duty_reg    <= duty_next;
            fwd_reg     <= fwd_next;
            tick_reg    <= tick_next;
        end
    end

    assign fwd_now    = fwd_next;
    assign spd.fwd    = fwd_next;
    assign spd.pw     = pw_lut[duty_next];
    assign spd.vel    = is_tick ? vel_pre_reg : 9'sd0;
    assign spd.report = is_tick & rpt_hit;

endmodule

// File: sv/bldc_hall_commutation_speed_loop_unit.sv
// ----------------------------------------------------------------------------
// bldc_hall_commutation_speed_loop_unit
// Six-step hall commutation with a proportional speed loop. Each input word
// is a hall edge (func 0) or a control tick (func 1) carrying the three hall
// bits, and each one gives exactly one result word: the six-switch enable
// pattern, the pwm on-time, the tracked rotor position, the velocity measured
// on a tick and a report flag on every REPORT_INTERVAL-th tick. The unit
// takes one word per clock when the output side is not stalled; a word sits
// in the input register while the compute stage works on it, and its result
// is written to the result register when the stage fires, where it waits
// until the output side is not stalled. That single compute stage, which also
// updates the rotor state, sets the rate. The output register lets the next
// word enter while a result waits; the input side stalls only when both
// registers are full and the output is stalled. Registers over apb: 0x0
// target_velocity (16 bit signed), 0x4 origin_rotor_state (3 bit),
// 0x8 speed_gain (10 bit, reset 300); write them only while idle.
// ----------------------------------------------------------------------------
module bldc_hall_commutation_speed_loop_unit
#(
    parameter int unsigned PWM_PERIOD_US   = bhcs_pkg::PWM_PERIOD_US_DEF,
    parameter int unsigned REPORT_INTERVAL = bhcs_pkg::REPORT_INTERVAL_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    // apb register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bhcs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,

    // input words
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        func,
    input  logic [2:0]                  hall_bits,

    // result words
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [5:0]                  switch_enable,
    output logic [10:0]                 pulse_width_us,
    output logic signed [7:0]           motor_position_out,
    output logic signed [8:0]           measured_velocity,
    output logic                        report_now
);

    localparam logic [10:0] PW_MAX = bhcs_pkg::pw_calc(PWM_PERIOD_US, 100);

    // configuration registers
    logic signed [15:0] target_reg;
    logic [2:0]         origin_reg;
    logic [9:0]         gain_reg;
    logic               cfg_wr;

    // input register
    logic               in_vld_reg;
    logic               func_reg;
    logic [2:0]         hall_reg;
    logic               in_take;
    logic               fire;

    // result register
    logic               out_vld_reg;
    logic [5:0]         sw_reg;
    logic [10:0]        pw_reg;
    logic [7:0]         pos_reg;
    logic signed [8:0]  vel_reg;
    logic               rpt_reg;

    logic [7:0]         pos_cur;
    logic               fwd_now;
    bhcs_pkg::com_t     com;
    bhcs_pkg::spd_t     spd;

    // ---------------- register port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            origin_reg <= '0;
            gain_reg   <= bhcs_pkg::GAIN_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                bhcs_pkg::REG_TARGET: target_reg <= pwdata[15:0];
                bhcs_pkg::REG_ORIGIN: origin_reg <= pwdata[2:0];
                bhcs_pkg::REG_GAIN:   gain_reg   <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            bhcs_pkg::REG_TARGET: prdata = {16'h0000, target_reg};
            bhcs_pkg::REG_ORIGIN: prdata = {29'h0, origin_reg};
            bhcs_pkg::REG_GAIN:   prdata = {22'h0, gain_reg};
            default:              prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    // compute stage fires when the result register is free or draining
    assign fire     = in_vld_reg & (~out_vld_reg | ~out_stall);
    assign in_stall = in_vld_reg & out_vld_reg & out_stall;
    assign in_take  = in_valid & ~in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_take | (in_vld_reg & ~fire);
            if (fire)
                out_vld_reg <= 1'b1;
            else if (!out_stall)
                out_vld_reg <= 1'b0;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg <= func;
            hall_reg <= hall_bits;
        end
    end

    // ---------------- compute stage ----------------
    // the speed loop settles duty and lead first, commutation then uses the
    // fresh lead, and the new position feeds the next tick's velocity
    bhcs_speed_loop
    #(
        .PWM_PERIOD_US   (PWM_PERIOD_US),
        .REPORT_INTERVAL (REPORT_INTERVAL)
    )
    u_speed
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .is_tick  (func_reg),
        .target   (target_reg),
        .gain     (gain_reg),
        .pos_cur  (pos_cur),
        .pos_next (com.pos),
        .fwd_now  (fwd_now),
        .spd      (spd)
    );

    bhcs_commutate u_commutate
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .hall_bits (hall_reg),
        .origin    (origin_reg),
        .fwd       (fwd_now),
        .pos_cur   (pos_cur),
        .com       (com)
    );

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            sw_reg  <= com.sw;
            pw_reg  <= spd.pw;
            pos_reg <= com.pos;
            vel_reg <= spd.vel;
            rpt_reg <= spd.report;
        end
    end

    assign out_valid          = out_vld_reg;
    assign switch_enable      = sw_reg;
    assign pulse_width_us     = pw_reg;
    assign motor_position_out = pos_reg;
    assign measured_velocity  = vel_reg;
    assign report_now         = rpt_reg;

    // ---------------- assertions ----------------
    // a word leaving the compute stage always lands in the result register
    a_fire_lands: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid)
        else $error("computed word did not reach the result register");

    // duty never exceeds full scale, so on-time stays at or below full period
    a_pw_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pulse_width_us <= PW_MAX))
        else $error("pulse width above full-duty on-time");

    // an 8-bit delta scaled by 5/3 stays within +-213
    a_vel_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (measured_velocity >= -9'sd213 && measured_velocity <= 9'sd213))
        else $error("measured velocity out of range");

endmodule
